>>> hdl/oaht_pkg.sv
// Shared types and constants for the open-addressing hash table unit.
// No dependencies; imported by every other file in hdl/.
`default_nettype none

package oaht_pkg;

    localparam int KEY_W          = 64;
    localparam int VAL_W          = 32;
    localparam int TABLE_SIZE_DEF = 1024;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_GET = 2'd1,
        CMD_DEL = 2'd2,
        CMD_NOP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        MARK_EMPTY   = 2'd0,
        MARK_FULL    = 2'd1,
        MARK_CLEARED = 2'd2
    } t_mark;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_ACT
    } t_state;

    typedef struct packed {
        t_cmd                    cmd;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] read_value;
    } t_out_item;

    // One slot of the table as held in the store.
    typedef struct packed {
        t_mark                   mark;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_slot;

endpackage

`default_nettype wire

>>> hdl/open_addressing_hash_table_unit.sv
// Open-addressing hash table with linear probing and tombstones: top level.
// Depends on oaht_pkg, oaht_home, oaht_store.
//
//   channel | dir | handshake                | beat
//   --------+-----+--------------------------+------------------------------
//   in      | in  | i_in_valid / o_in_stall  | t_in_item  {cmd, key, value}
//   out     | out | o_out_valid / i_out_stall| t_out_item {status, read_value}
//
// One command at a time. Each item is hashed to its home slot and then probes
// P slots (one store read per cycle, P from 1 to TABLE_SIZE); a size that is
// not a power of two runs a stepwise home slot reduction. cmd 3 skips both.
// After reset a clearing pass writes every slot empty, with o_in_stall high
// throughout. The result sits in an output register; the next beat is
// taken while it waits, and the unit holds in its last step if it still waits.
`default_nettype none

module open_addressing_hash_table_unit #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  oaht_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output oaht_pkg::t_out_item o_out
);
    import oaht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);

    t_state                  r_state, n_state;
    t_cmd                    r_cmd, n_cmd;
    logic [KEY_W-1:0]        r_key, n_key;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic [IDX_W-1:0]        r_addr, n_addr;
    logic [IDX_W-1:0]        r_n, n_n;
    logic [IDX_W-1:0]        r_free, n_free;
    logic                    r_free_ok, n_free_ok;
    logic                    r_hit, n_hit;
    logic signed [VAL_W-1:0] r_found, n_found;
    logic [IDX_W-1:0]        r_clr, n_clr;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;

    logic             hash_start;
    logic             home_done;
    logic [IDX_W-1:0] home;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_slot            mem_wdata;
    t_slot            slot;
    logic             match;
    logic             last;
    logic [IDX_W-1:0] addr_nx;
    logic             adv;

    oaht_home #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_home (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (n_key),
        .o_done  (home_done),
        .o_home  (home)
    );

    oaht_store #(
        .DEPTH (TABLE_SIZE)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (n_addr),
        .o_rdata (slot)
    );

    assign match   = (slot.mark == MARK_FULL) && (slot.key == r_key);
    assign last    = (r_n == IDX_W'(TABLE_SIZE - 1));
    assign addr_nx = (r_addr == IDX_W'(TABLE_SIZE - 1)) ? '0 : r_addr + 1'b1;
    assign adv     = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_value     = r_value;
        n_addr      = r_addr;
        n_n         = r_n;
        n_free      = r_free;
        n_free_ok   = r_free_ok;
        n_hit       = r_hit;
        n_found     = r_found;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        hash_start  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = '{mark: MARK_FULL, key: r_key, value: r_value};

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '{mark: MARK_EMPTY, key: '0, value: '0};
                n_clr     = r_clr + 1'b1;
                if (r_clr == IDX_W'(TABLE_SIZE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in.cmd;
                    n_key   = i_in.key;
                    n_value = i_in.value;
                    if (i_in.cmd == CMD_NOP) begin
                        n_state = S_ACT;
                    end else begin
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end
                end
            end
            S_HASH: begin
                n_free_ok = 1'b0;
                n_n       = '0;
                if (home_done) begin
                    n_addr  = home;
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                // first non-full slot on the path is where a new key goes
                if (slot.mark != MARK_FULL && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_addr;
                end
                if (match) begin
                    n_hit   = 1'b1;
                    n_found = slot.value;
                    n_state = S_ACT;
                end else if (slot.mark == MARK_EMPTY || last) begin
                    n_hit   = 1'b0;
                    n_state = S_ACT;
                end else begin
                    n_addr = addr_nx;
                    n_n    = r_n + 1'b1;
                end
            end
            S_ACT: begin
                if (adv) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_OK, read_value: '0};
                    n_state     = S_IDLE;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (r_hit) begin
                                mem_we = 1'b1;
                            end else if (r_free_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_free;
                            end else begin
                                n_out.status = ST_FULL;
                            end
                        end
                        CMD_GET: begin
                            if (r_hit) begin
                                n_out.read_value = r_found;
                            end else begin
                                n_out.status = ST_ABSENT;
                            end
                        end
                        CMD_DEL: begin
                            if (r_hit) begin
                                mem_we         = 1'b1;
                                mem_wdata.mark = MARK_CLEARED;
                            end else begin
                                n_out.status = ST_ABSENT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_free_ok   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_free_ok   <= n_free_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_value <= n_value;
        r_addr  <= n_addr;
        r_n     <= n_n;
        r_free  <= n_free;
        r_hit   <= n_hit;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

>>> hdl/oaht_home.sv
// Home slot unit: key mod TABLE_SIZE.
// Depends on oaht_pkg. Power-of-two sizes register the low key bits directly;
// other sizes run a restoring reduction, 8 key bits per cycle.
`default_nettype none

module oaht_home #(
    parameter int TABLE_SIZE = oaht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [oaht_pkg::KEY_W-1:0]    i_key,
    output logic                               o_done,
    output logic [$clog2(TABLE_SIZE)-1:0]      o_home
);
    import oaht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam bit POW2  = ((TABLE_SIZE & (TABLE_SIZE - 1)) == 0);

    logic [IDX_W-1:0] r_rem;
    logic             r_done;

    if (POW2) begin : g_mask
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else if (i_start) begin
                r_done <= 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_rem <= i_key[IDX_W-1:0];
            end
        end
    end else begin : g_div
        localparam int BITS_PER_STEP = 8;
        localparam int STEPS         = KEY_W / BITS_PER_STEP;
        localparam int CNT_W         = $clog2(STEPS);

        logic [KEY_W-1:0] r_sh;
        logic [CNT_W-1:0] r_cnt;
        logic             r_busy;
        logic [IDX_W-1:0] n_rem;

        // Shift in one key bit at a time, MSB first; remainder stays below N.
        always_comb begin
            logic [IDX_W:0] t;
            t     = '0;
            n_rem = r_rem;
            for (int b = 0; b < BITS_PER_STEP; b++) begin
                t = {n_rem, r_sh[KEY_W-1-b]};
                if (t >= (IDX_W+1)'(TABLE_SIZE)) begin
                    t = t - (IDX_W+1)'(TABLE_SIZE);
                end
                n_rem = t[IDX_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_busy <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_start) begin
                r_rem <= '0;
                r_sh  <= i_key;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_sh  <= r_sh << BITS_PER_STEP;
            end
        end
    end

    assign o_done = r_done;
    assign o_home = r_rem;

endmodule

`default_nettype wire

>>> hdl/oaht_store.sv
// Slot store: one write port, one read port, registered read data.
// Depends on oaht_pkg for the slot type.
`default_nettype none

module oaht_store #(
    parameter int DEPTH = oaht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  oaht_pkg::t_slot                 i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output oaht_pkg::t_slot                 o_rdata
);
    import oaht_pkg::*;

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/oaht_chk.sv
// Port-level checker for open_addressing_hash_table_unit, bound to the top.
// Depends on oaht_pkg.
`default_nettype none

module oaht_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input oaht_pkg::t_in_item  i_in,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input oaht_pkg::t_out_item o_out
);
    import oaht_pkg::*;

    // A result waiting on a stall stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // Only a successful get returns a nonzero value.
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_OK) |-> (o_out.read_value == '0))
        else $error("read_value nonzero on failed command");

    // Reset starts the clearing pass, which refuses input.
    a_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input open right after reset");

    // One command at a time: after an accepted beat the unit is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second beat taken while a command is in flight");

endmodule

bind open_addressing_hash_table_unit oaht_chk u_oaht_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

`default_nettype wire

>>> dv/open_addressing_hash_table_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for open_addressing_hash_table_unit: queue-fed command driver,
// reply monitor and a slot-level model of the probing table. Depends on oaht_pkg.
module open_addressing_hash_table_unit_tb;
    import oaht_pkg::*;

    localparam int TBL         = TABLE_SIZE_DEF;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int POOL_N      = 40;
    localparam int RAND_HALF   = 200;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_LEN    = 400;
    localparam int TAIL_CYCLES = 100;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;

    open_addressing_hash_table_unit #(.TABLE_SIZE(TBL)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out       (o_out)
    );

    always #2 i_clk = ~i_clk;

    // table model
    logic [KEY_W-1:0]        slot_key_m  [TBL];
    logic signed [VAL_W-1:0] slot_val_m  [TBL];
    t_mark                   slot_mark_m [TBL];
    int unsigned             live_slots = 0;

    t_in_item  pending_cmds[$];
    t_out_item predicted_replies[$];
    t_out_item want;

    int   n_accepted   = 0;
    int   n_replies    = 0;
    int   n_errors     = 0;
    int   n_hits       = 0;
    int   n_absent     = 0;
    int   n_full       = 0;
    int   send_gap     = 0;
    int   recv_gap     = 0;
    int   hold_left    = 0;
    int   cycle_count  = 0;
    logic hold_armed   = 1'b1;
    logic hold_mark    = 1'b0;
    logic calm         = 1'b0;

    function automatic int home_of(logic [KEY_W-1:0] k);
        return int'(k % 64'(TBL));
    endfunction

    function automatic bit lookup(logic [KEY_W-1:0] k, output int at);
        int s;
        s  = home_of(k);
        at = 0;
        for (int n = 0; n < TBL; n++) begin
            if (slot_mark_m[s] == MARK_EMPTY) return 1'b0;
            if (slot_mark_m[s] == MARK_FULL && slot_key_m[s] == k) begin
                at = s;
                return 1'b1;
            end
            s = (s + 1 == TBL) ? 0 : s + 1;
        end
        return 1'b0;
    endfunction

    function automatic t_out_item table_apply(t_in_item it);
        t_out_item r;
        int        at;
        int        s;
        bit        hit;
        bit        placed;
        r.status     = ST_OK;
        r.read_value = '0;
        hit = lookup(it.key, at);
        case (it.cmd)
            CMD_ADD: begin
                if (hit) begin
                    slot_val_m[at] = it.value;
                end else begin
                    // first empty or cleared slot on the probe path
                    s      = home_of(it.key);
                    placed = 1'b0;
                    for (int n = 0; n < TBL && !placed; n++) begin
                        if (slot_mark_m[s] != MARK_FULL) begin
                            slot_key_m[s]  = it.key;
                            slot_val_m[s]  = it.value;
                            slot_mark_m[s] = MARK_FULL;
                            live_slots++;
                            placed = 1'b1;
                        end else begin
                            s = (s + 1 == TBL) ? 0 : s + 1;
                        end
                    end
                    if (!placed) begin
                        r.status = ST_FULL;
                        n_full++;
                    end
                end
            end
            CMD_GET: begin
                if (hit) begin
                    r.read_value = slot_val_m[at];
                    n_hits++;
                end else begin
                    r.status = ST_ABSENT;
                    n_absent++;
                end
            end
            CMD_DEL: begin
                if (hit) begin
                    slot_mark_m[at] = MARK_CLEARED;
                    live_slots--;
                end else begin
                    r.status = ST_ABSENT;
                    n_absent++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predicted_replies.push_back(table_apply(in_beat));
                n_accepted++;
                send_gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
            end
            if (!in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    in_beat  <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            hold_mark <= 1'b0;
            recv_gap = 0;
        end else begin
            if (o_out_valid && !out_stall) begin
                n_replies++;
                if (predicted_replies.size() == 0) begin
                    $error("reply with nothing pending: status %0d read_value %0d",
                           o_out.status, o_out.read_value);
                    n_errors++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (o_out.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_out.status);
                        n_errors++;
                    end
                    if (o_out.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, actual %0d",
                               want.read_value, o_out.read_value);
                        n_errors++;
                    end
                end
            end
            hold_mark <= (n_replies >= HOLD_AT);
            if (recv_gap > 0) recv_gap--;
            else if (!calm && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 12);
            out_stall <= (recv_gap > 0) || (hold_left != 0);
        end
    end

    // one long output hold-off while the driver keeps offering beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && hold_mark) begin
            hold_left  <= HOLD_LEN;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, predicted_replies.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic queue_cmd(t_cmd c, logic [KEY_W-1:0] k, logic signed [VAL_W-1:0] v);
        t_in_item it;
        it.cmd   = c;
        it.key   = k;
        it.value = v;
        pending_cmds.push_back(it);
    endtask

    task automatic wait_drained();
        while (in_valid || pending_cmds.size() != 0 || predicted_replies.size() != 0)
            @(negedge i_clk);
    endtask

    logic [KEY_W-1:0]        pool_keys [POOL_N];
    logic [KEY_W-1:0]        k;
    logic signed [VAL_W-1:0] v;
    t_cmd                    c;
    int                      base;
    int                      home;
    int                      pick;
    int                      free_slots;
    localparam logic [KEY_W-1:0] ONES      = '1;
    localparam logic [KEY_W-1:0] FILL_BASE = 64'hF11E_0000_0000_0000;
    localparam logic [KEY_W-1:0] SPARE     = 64'hF11F_0000_0000_0000;

    initial begin
        for (int i = 0; i < TBL; i++) begin
            slot_mark_m[i] = MARK_EMPTY;
            slot_key_m[i]  = '0;
            slot_val_m[i]  = '0;
        end
        // two clusters of colliding keys; the second wraps past the last slot
        for (int i = 0; i < POOL_N; i++) begin
            base = (i < POOL_N / 2) ? 37 : TBL - 8;
            home = (base + $urandom_range(0, 15)) % TBL;
            k    = {$urandom, $urandom};
            pool_keys[i] = k - (k % 64'(TBL)) + 64'(home);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, update, wraparound collision, tombstone skip and reuse
        queue_cmd(CMD_GET, '0, '0);
        queue_cmd(CMD_DEL, '0, '0);
        queue_cmd(CMD_ADD, '0, 32'sh7FFF_FFFF);
        queue_cmd(CMD_GET, '0, '0);
        queue_cmd(CMD_ADD, '0, 32'sh8000_0000);
        queue_cmd(CMD_GET, '0, '1);
        queue_cmd(CMD_ADD, ONES, -32'sd1);
        queue_cmd(CMD_ADD, 64'(TBL - 1), '0);
        queue_cmd(CMD_GET, ONES, '0);
        queue_cmd(CMD_GET, 64'(TBL - 1), '0);
        queue_cmd(CMD_DEL, ONES, '0);
        queue_cmd(CMD_GET, 64'(TBL - 1), '0);
        queue_cmd(CMD_DEL, ONES, '0);
        queue_cmd(CMD_ADD, 64'(TBL - 1), 32'sd12345);
        queue_cmd(CMD_ADD, ONES, 32'sd5);
        queue_cmd(CMD_GET, ONES, '0);
        queue_cmd(CMD_NOP, ONES, '1);
        queue_cmd(CMD_GET, 64'(TBL), '0);
        queue_cmd(CMD_DEL, '0, '0);
        queue_cmd(CMD_GET, '0, '0);
        queue_cmd(CMD_GET, 64'(TBL - 1), '0);
        queue_cmd(CMD_ADD, '0, '0);
        queue_cmd(CMD_GET, '0, '0);
        wait_drained();

        // random mix on the clustered pool, with a pause between the halves
        for (int half = 0; half < 2; half++) begin
            for (int i = 0; i < RAND_HALF; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 38)      c = CMD_ADD;
                else if (pick < 72) c = CMD_GET;
                else if (pick < 96) c = CMD_DEL;
                else                c = CMD_NOP;
                if ($urandom_range(0, 6) == 0) k = {$urandom, $urandom};
                else                           k = pool_keys[$urandom_range(0, POOL_N - 1)];
                case ($urandom_range(0, 15))
                    0:       v = 32'sh7FFF_FFFF;
                    1:       v = 32'sh8000_0000;
                    default: v = $urandom;
                endcase
                queue_cmd(c, k, v);
            end
            wait_drained();
        end

        // no idling from here: fill every slot, then run against a full table
        calm = 1'b1;
        free_slots = TBL - int'(live_slots);
        for (int i = 0; i < free_slots; i++) queue_cmd(CMD_ADD, FILL_BASE + 64'(i), $urandom);
        wait_drained();
        queue_cmd(CMD_ADD, SPARE, 32'sd1);
        queue_cmd(CMD_GET, SPARE, '0);
        queue_cmd(CMD_DEL, SPARE, '0);
        queue_cmd(CMD_ADD, FILL_BASE, 32'sh8000_0000);
        queue_cmd(CMD_GET, FILL_BASE, '0);
        queue_cmd(CMD_DEL, FILL_BASE + 64'd5, '0);
        queue_cmd(CMD_ADD, SPARE + 64'd1, 32'sh7FFF_FFFF);
        queue_cmd(CMD_ADD, SPARE + 64'd2, 32'sd2);
        queue_cmd(CMD_GET, SPARE + 64'd1, '0);
        queue_cmd(CMD_NOP, SPARE, '0);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("%0d beats in, %0d replies checked: %0d get hits, %0d absent, %0d table full",
                 n_accepted, n_replies, n_hits, n_absent, n_full);
        $display("covered collision clusters with wraparound, tombstone reuse, a full table "
                 , "and a %0d-cycle output hold", HOLD_LEN);
        if (n_errors == 0 && predicted_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
